>>> hw/rtl/sdfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdfm_pkg
// Shared constants, types and the hue colour function for the frame modulator.
// ----------------------------------------------------------------------------
package sdfm_pkg;

   localparam int unsigned FramePixelsDefault = 37;
   localparam int unsigned HueScale = 224;
   localparam int unsigned HueSegment = 43;
   localparam int unsigned HueStep = 6;
   localparam logic [7:0] FullScale = 8'd255;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_DIST = 2'd1,
      MODE_SWAY = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      FIX_OTHER = 2'd0,
      FIX_HEX = 2'd1,
      FIX_DOWN = 2'd2,
      FIX_UNUSED = 2'd3
   } fixture_type;

   typedef enum logic [2:0] {
      REG_NEAR = 3'd0,
      REG_MAX = 3'd1,
      REG_CLOSE = 3'd2,
      REG_MID = 3'd3,
      REG_FAR = 3'd4,
      REG_SWAY = 3'd5,
      REG_FIXTURE = 3'd6,
      REG_SWAY_EN = 3'd7
   } reg_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_HUE_DIV,
      ST_MODIFY,
      ST_NORM_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [15:0] near_mm;
      logic [15:0] max_mm;
      logic [15:0] close_mm;
      logic [15:0] mid_mm;
      logic [15:0] far_ring_mm;
      logic [15:0] sway_trigger_mg;
      logic [1:0]  fixture_kind;
      logic        sway_enable;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [23:0] quotient;
   } div_rsp_type;

   // hue (0..255) to rgb packed as {b, g, r}
   function automatic logic [23:0] hue_rgb(input logic [7:0] hue);
      logic [2:0] seg;
      logic [7:0] rem;
      logic [7:0] q;
      logic [23:0] res;
      if (hue < 8'd43) seg = 3'd0;
      else if (hue < 8'd86) seg = 3'd1;
      else if (hue < 8'd129) seg = 3'd2;
      else if (hue < 8'd172) seg = 3'd3;
      else if (hue < 8'd215) seg = 3'd4;
      else seg = 3'd5;
      rem = 8'((hue - 8'(seg) * 8'(HueSegment)) * 8'(HueStep));
      q = FullScale - rem;
      case (seg)
         3'd0: res = {8'd0, rem, FullScale};
         3'd1: res = {8'd0, FullScale, q};
         3'd2: res = {rem, FullScale, 8'd0};
         3'd3: res = {FullScale, q, 8'd0};
         3'd4: res = {FullScale, 8'd0, rem};
         default: res = {q, 8'd0, FullScale};
      endcase
      return res;
   endfunction

endpackage : sdfm_pkg
`default_nettype wire

>>> hw/rtl/sensor_driven_frame_modulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_driven_frame_modulator_top
// Frame store with distance hue and sway normalisation, shared serial divider.
// ----------------------------------------------------------------------------
// Pixels are taken one a cycle into a frame store while the block is in its
// load state. The frame_end word starts processing: a distance effect costs one
// 24-bit divide for the hue plus one pass over the frame, sway normalisation
// costs one 24-bit divide per channel of each pixel, and emission gives one word
// a cycle when not stalled. The block takes no input from frame_end until the
// last pixel has been delivered. The single divider and the one-port frame
// store set this pace.
module sensor_driven_frame_modulator_top #(
   parameter int unsigned FRAME_PIXELS = sdfm_pkg::FramePixelsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_white_in,
   input  wire logic [1:0]  req_pixel_ring,
   input  wire logic        req_frame_end,
   input  wire logic        req_range_valid,
   input  wire logic [15:0] req_range_mm,
   input  wire logic        req_sway_valid,
   input  wire logic [15:0] req_sway_mg,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_white_out,
   output logic             rsp_last_pixel,
   output logic [1:0]       rsp_applied_mode,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import sdfm_pkg::*;

   localparam int unsigned CW = $clog2(FRAME_PIXELS + 1);
   localparam int unsigned AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   cfg_type     cfg;
   div_req_type dreq;
   div_rsp_type drsp;

   sdfm_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
      .pready, .cfg
   );
   sdfm_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   logic [31:0] pix_mem [FRAME_PIXELS];
   logic [1:0]  ring_mem [FRAME_PIXELS];

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]  peak_ff, peak_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0]  chan_ff, chan_in;
   logic        issued_ff, issued_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] dist_ff, dist_in;
   logic [1:0]  top_ff, top_in;
   logic [23:0] rgb_ff, rgb_in;
   logic [31:0] work_ff, work_in;

   // frame store port, one access a cycle
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0] mem_wdata;
   logic [1:0]  mem_wring;
   logic [31:0] rd_pix_ff;
   logic [1:0]  rd_ring_ff;
   logic        rd_ok_ff, rd_ok_in;

   logic        acc;
   logic [7:0]  in_peak;
   logic [31:0] in_word;
   logic        full;
   logic [CW-1:0] n_frame;
   logic        dist_ok, hex_ok, down_ok, sway_ok;
   logic        out_ok;
   logic [7:0]  ch_val;
   logic [15:0] span;

   assign full = (count_ff == CW'(FRAME_PIXELS));
   assign req_stall = (state_ff != ST_LOAD);
   assign acc = req_valid && !req_stall;
   assign in_word = {req_white_in, req_blue_in, req_green_in, req_red_in};

   // frame size once the current word is stored
   assign n_frame = full ? count_ff : count_ff + CW'(1);

   always_comb begin
      in_peak = peak_ff;
      if (req_red_in > in_peak) in_peak = req_red_in;
      if (req_green_in > in_peak) in_peak = req_green_in;
      if (req_blue_in > in_peak) in_peak = req_blue_in;
      if (req_white_in > in_peak) in_peak = req_white_in;
      if (full) in_peak = peak_ff;
   end

   assign span = cfg.max_mm - cfg.near_mm;
   assign dist_ok = req_range_valid && (req_range_mm >= cfg.near_mm)
                    && (req_range_mm <= cfg.max_mm);
   assign hex_ok = (cfg.fixture_kind == FIX_HEX) && (n_frame == CW'(FRAME_PIXELS));
   assign down_ok = (cfg.fixture_kind == FIX_DOWN) && (n_frame == CW'(1));
   assign sway_ok = cfg.sway_enable && req_sway_valid && (req_sway_mg >= cfg.sway_trigger_mg)
                    && (in_peak != FullScale);

   always_comb begin
      case (chan_ff)
         2'd0: ch_val = rd_pix_ff[7:0];
         2'd1: ch_val = rd_pix_ff[15:8];
         2'd2: ch_val = rd_pix_ff[23:16];
         default: ch_val = rd_pix_ff[31:24];
      endcase
   end

   assign out_ok = (state_ff == ST_EMIT) && rd_ok_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (acc && req_frame_end) begin
               if (in_peak != 8'd0 && dist_ok && (hex_ok || down_ok)) state_in = ST_HUE_DIV;
               else if (in_peak != 8'd0 && sway_ok) state_in = ST_NORM_DIV;
               else state_in = ST_EMIT;
            end
         end
         ST_HUE_DIV: if (issued_ff && drsp.done) state_in = ST_MODIFY;
         ST_MODIFY: if (rd_ok_ff && idx_ff == count_ff - CW'(1)) state_in = ST_EMIT;
         ST_NORM_DIV: begin
            if (drsp.done && chan_ff == 2'd3 && idx_ff == count_ff - CW'(1))
               state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_ok && !rsp_stall && rsp_last_pixel) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff;
      peak_in = peak_ff;
      idx_in = idx_ff;
      chan_in = chan_ff;
      issued_in = 1'b0;
      mode_in = mode_ff;
      dist_in = dist_ff;
      top_in = top_ff;
      rgb_in = rgb_ff;
      work_in = work_ff;
      rd_ok_in = 1'b0;
      mem_we = 1'b0;
      mem_addr = idx_ff[AW-1:0];
      mem_wdata = work_ff;
      mem_wring = req_pixel_ring;
      dreq = '0;
      case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               if (!full) begin
                  mem_we = 1'b1;
                  mem_addr = count_ff[AW-1:0];
                  mem_wdata = in_word;
                  count_in = count_ff + CW'(1);
               end
               peak_in = in_peak;
               if (req_frame_end) begin
                  idx_in = '0;
                  chan_in = 2'd0;
                  dist_in = req_range_mm;
                  mode_in = MODE_NONE;
                  if (req_range_mm <= cfg.close_mm) top_in = 2'd0;
                  else if (req_range_mm <= cfg.mid_mm) top_in = 2'd1;
                  else if (req_range_mm <= cfg.far_ring_mm) top_in = 2'd2;
                  else top_in = 2'd3;
                  if (in_peak != 8'd0 && dist_ok && (hex_ok || down_ok)) begin
                     mode_in = MODE_DIST;
                     dreq.start = 1'b1;
                     dreq.dividend = 24'((req_range_mm - cfg.near_mm) * 24'(HueScale));
                     dreq.divisor = span;
                     issued_in = 1'b1;
                  end else if (in_peak != 8'd0 && sway_ok) begin
                     mode_in = MODE_SWAY;
                  end
               end
            end
         end
         ST_HUE_DIV: begin
            issued_in = issued_ff;
            if (drsp.done) begin
               rgb_in = hue_rgb((span == 16'd0) ? 8'd0 : drsp.quotient[7:0]);
               rd_ok_in = 1'b1;
            end
         end
         ST_MODIFY: begin
            rd_ok_in = 1'b1;
            if (rd_ok_ff) begin
               mem_we = 1'b1;
               if (cfg.fixture_kind == FIX_DOWN)
                  mem_wdata = (dist_ff <= cfg.close_mm) ? {FullScale, 24'd0} : {8'd0, rgb_ff};
               else
                  mem_wdata = (rd_ring_ff <= top_ff) ? {8'd0, rgb_ff} : 32'd0;
               idx_in = idx_ff + CW'(1);
               mem_addr = idx_ff[AW-1:0];
               rd_ok_in = 1'b0;
               if (idx_ff == count_ff - CW'(1)) idx_in = '0;
            end
         end
         ST_NORM_DIV: begin
            // issue per channel once the pixel word is read back
            if (!rd_ok_ff && !drsp.busy && !drsp.done && !issued_ff) begin
               rd_ok_in = 1'b1;
            end else if (rd_ok_ff && !issued_ff) begin
               dreq.start = 1'b1;
               dreq.dividend = {8'd0, 16'(ch_val) * 16'(FullScale)};
               dreq.divisor = {8'd0, peak_ff};
               issued_in = 1'b1;
               rd_ok_in = 1'b1;
            end else if (issued_ff) begin
               issued_in = !drsp.done;
               rd_ok_in = rd_ok_ff;
               if (drsp.done) begin
                  case (chan_ff)
                     2'd0: work_in[7:0] = drsp.quotient[7:0];
                     2'd1: work_in[15:8] = drsp.quotient[7:0];
                     2'd2: work_in[23:16] = drsp.quotient[7:0];
                     default: work_in[31:24] = drsp.quotient[7:0];
                  endcase
                  chan_in = chan_ff + 2'd1;
                  if (chan_ff == 2'd3) begin
                     mem_we = 1'b1;
                     mem_wdata = {drsp.quotient[7:0], work_ff[23:0]};
                     rd_ok_in = 1'b0;
                     idx_in = (idx_ff == count_ff - CW'(1)) ? '0 : idx_ff + CW'(1);
                  end
               end
            end
         end
         ST_EMIT: begin
            rd_ok_in = rd_ok_ff;
            if (!rd_ok_ff) rd_ok_in = 1'b1;
            else if (!rsp_stall) begin
               if (rsp_last_pixel) begin
                  rd_ok_in = 1'b0;
                  count_in = '0;
                  peak_in = '0;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + CW'(1);
                  mem_addr = idx_in[AW-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_mem[mem_addr] <= mem_wdata;
         if (state_ff == ST_LOAD) ring_mem[mem_addr] <= mem_wring;
      end
      rd_pix_ff <= pix_mem[mem_addr];
      rd_ring_ff <= ring_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         peak_ff <= '0;
         idx_ff <= '0;
         chan_ff <= '0;
         issued_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         peak_ff <= peak_in;
         idx_ff <= idx_in;
         chan_ff <= chan_in;
         issued_ff <= issued_in;
         rd_ok_ff <= rd_ok_in;
      end
      mode_ff <= mode_in;
      dist_ff <= dist_in;
      top_ff <= top_in;
      rgb_ff <= rgb_in;
      work_ff <= work_in;
   end

   // read data is registered; in emit it is held steady while stalled
   assign rsp_valid = out_ok;
   assign rsp_red_out = rd_pix_ff[7:0];
   assign rsp_green_out = rd_pix_ff[15:8];
   assign rsp_blue_out = rd_pix_ff[23:16];
   assign rsp_white_out = rd_pix_ff[31:24];
   assign rsp_last_pixel = (idx_ff == count_ff - CW'(1));
   assign rsp_applied_mode = mode_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FRAME_PIXELS))
      else $error("pixel count beyond frame size");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> count_ff != '0)
      else $error("emitting empty frame");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> req_stall)
      else $error("accepting while busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_pixel |=> count_ff == '0 && peak_ff == '0)
      else $error("frame state not cleared");
`endif
endmodule : sensor_driven_frame_modulator_top
`default_nettype wire

>>> hw/rtl/sdfm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdfm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdfm_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sdfm_pkg::div_req_type req,
   output sdfm_pkg::div_rsp_type     rsp
);
   import sdfm_pkg::*;

   logic [23:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dsr_in = dsr_ff;
      trial = {rem_ff[15:0], quo_ff[23]};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without run");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 5'd23)
      else $error("divider count overrun");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
`endif
endmodule : sdfm_div
`default_nettype wire

>>> hw/rtl/sdfm_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdfm_csr
// Configuration register file behind the apb-style port.
// ----------------------------------------------------------------------------
module sdfm_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output sdfm_pkg::cfg_type cfg
);
   import sdfm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;
   reg_type idx;

   assign idx = reg_type'(paddr[4:2]);
   assign wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_NEAR:    cfg_in.near_mm = pwdata[15:0];
            REG_MAX:     cfg_in.max_mm = pwdata[15:0];
            REG_CLOSE:   cfg_in.close_mm = pwdata[15:0];
            REG_MID:     cfg_in.mid_mm = pwdata[15:0];
            REG_FAR:     cfg_in.far_ring_mm = pwdata[15:0];
            REG_SWAY:    cfg_in.sway_trigger_mg = pwdata[15:0];
            REG_FIXTURE: cfg_in.fixture_kind = pwdata[1:0];
            default:     cfg_in.sway_enable = pwdata[0];
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_NEAR:    prdata = {16'd0, cfg_ff.near_mm};
         REG_MAX:     prdata = {16'd0, cfg_ff.max_mm};
         REG_CLOSE:   prdata = {16'd0, cfg_ff.close_mm};
         REG_MID:     prdata = {16'd0, cfg_ff.mid_mm};
         REG_FAR:     prdata = {16'd0, cfg_ff.far_ring_mm};
         REG_SWAY:    prdata = {16'd0, cfg_ff.sway_trigger_mg};
         REG_FIXTURE: prdata = {30'd0, cfg_ff.fixture_kind};
         default:     prdata = {31'd0, cfg_ff.sway_enable};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_mm <= 16'd100;
         cfg_ff.max_mm <= 16'd1500;
         cfg_ff.close_mm <= 16'd300;
         cfg_ff.mid_mm <= 16'd600;
         cfg_ff.far_ring_mm <= 16'd900;
         cfg_ff.sway_trigger_mg <= 16'd100;
         cfg_ff.fixture_kind <= FIX_OTHER;
         cfg_ff.sway_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg = cfg_ff;
endmodule : sdfm_csr
`default_nettype wire
